FILE: sv/dual_cpu_mailbox_fifo_defines.svh
// Assertion macros shared by the mailbox RTL.
`ifndef DUAL_CPU_MAILBOX_FIFO_DEFINES_SVH
`define DUAL_CPU_MAILBOX_FIFO_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define DCMF_ASSERT(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define DCMF_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: sv/dcmf_pkg.sv
// Types, address map and helper function of the dual CPU mailbox.
package dcmf_pkg;

    // Access codes
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Event kinds
    localparam logic [1:0] EV_SYNC           = 2'd0;
    localparam logic [1:0] EV_SEND_EMPTY     = 2'd1;
    localparam logic [1:0] EV_RECV_NOT_EMPTY = 2'd2;

    // Register address map
    localparam logic [26:0] ADDR_SYNC_LO = 27'h4000180;
    localparam logic [26:0] ADDR_SYNC_HI = 27'h4000181;
    localparam logic [26:0] ADDR_CNT_LO  = 27'h4000184;
    localparam logic [26:0] ADDR_CNT_HI  = 27'h4000185;
    localparam logic [26:0] ADDR_SEND0   = 27'h4000188;
    localparam logic [26:0] ADDR_RECV0   = 27'h4100000;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } dcmf_state_t;

    // One bus access
    typedef struct packed {
        logic        side;
        logic        opcode;
        logic [26:0] address;
        logic [7:0]  write_byte;
        logic        last_byte;
    } acc_t;

    // Result of one access
    typedef struct packed {
        logic [7:0] read_byte;
        logic       event_valid;
        logic       event_side;
        logic [1:0] event_kind;
    } res_t;

    // FIFO memory command (addresses travel separately, sized by depth)
    typedef struct packed {
        logic        wr_en;
        logic        wr_side;
        logic [31:0] wr_data;
        logic        rd_en;
        logic        rd_side;
    } mem_cmd_t;

    // Receive latch capture from memory read data
    typedef struct packed {
        logic        en;
        logic        side;
        logic [31:0] data;
    } cap_t;

    // Align gathered bytes to lane 0, then replicate single bytes or halfwords
    function automatic logic [31:0] mirror_word(input logic [31:0] w, input logic [3:0] lanes);
        logic [31:0] v;
        logic [3:0]  l;
        if (lanes[0])
        begin
            v = w;
            l = lanes;
        end
        else if (lanes[1])
        begin
            v = w >> 8;
            l = lanes >> 1;
        end
        else if (lanes[2])
        begin
            v = w >> 16;
            l = lanes >> 2;
        end
        else if (lanes[3])
        begin
            v = w >> 24;
            l = lanes >> 3;
        end
        else
        begin
            v = w;
            l = 4'd0;
        end
        if (l == 4'd1)
            v = {4{v[7:0]}};
        else if (l == 4'd3)
            v = {2{v[15:0]}};
        return v;
    endfunction

endpackage

FILE: sv/dcmf_ifs.sv
// Access and result channel interfaces of the mailbox.
interface dcmf_acc_if;
    logic        valid;
    logic        ready;
    logic        side;
    logic        opcode;
    logic [26:0] address;
    logic [7:0]  write_byte;
    logic        last_byte;

    modport source (output valid, side, opcode, address, write_byte, last_byte, input ready);
    modport sink (input valid, side, opcode, address, write_byte, last_byte, output ready);
endinterface

interface dcmf_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_byte;
    logic       event_valid;
    logic       event_side;
    logic [1:0] event_kind;

    modport source (output valid, read_byte, event_valid, event_side, event_kind, input ready);
    modport sink (input valid, read_byte, event_valid, event_side, event_kind, output ready);
endinterface

FILE: sv/dcmf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dcmf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

FILE: sv/dcmf_core.sv
// Per-side mailbox registers, address decode and FIFO pointer logic.
module dcmf_core
    import dcmf_pkg::*;
#(
    parameter int FIFO_DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  acc_t                          acc,
    input  cap_t                          cap,
    output res_t                          res,
    output mem_cmd_t                      mem,
    output logic [$clog2(FIFO_DEPTH)-1:0] wr_addr,
    output logic [$clog2(FIFO_DEPTH)-1:0] rd_addr
);

`include "dual_cpu_mailbox_fifo_defines.svh"

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CW = PW + 1;

    // Per-side state
    logic [PW-1:0] head_reg [2];
    logic [PW-1:0] head_next [2];
    logic [CW-1:0] count_reg [2];
    logic [CW-1:0] count_next [2];
    logic [3:0]    sync_reg [2];
    logic [3:0]    sync_next [2];
    logic          sync_en_reg [2];
    logic          sync_en_next [2];
    logic          send_irq_reg [2];
    logic          send_irq_next [2];
    logic          recv_irq_reg [2];
    logic          recv_irq_next [2];
    logic          err_reg [2];
    logic          err_next [2];
    logic          enable_reg [2];
    logic          enable_next [2];
    logic [31:0]   asm_reg [2];
    logic [31:0]   asm_next [2];
    logic [3:0]    lanes_reg [2];
    logic [3:0]    lanes_next [2];
    logic [31:0]   latch_reg [2];
    logic [31:0]   latch_next [2];

    logic          s_idx;
    logic          o_idx;
    logic [1:0]    lane;
    logic [31:0]   gathered;
    logic [3:0]    glanes;
    logic [31:0]   word;
    logic [PW:0]   sum;
    logic [PW:0]   inc;
    logic          lvl_before;
    logic          lvl_after;

    // Decode and next-state logic for one access
    always_comb
    begin
        s_idx         = acc.side;
        o_idx         = ~acc.side;
        lane          = acc.address[1:0];
        gathered      = asm_reg[s_idx] | ({24'd0, acc.write_byte} << {lane, 3'b000});
        glanes        = lanes_reg[s_idx] | (4'd1 << lane);
        word          = mirror_word(gathered, glanes);
        sum           = {1'b0, head_reg[s_idx]} + count_reg[s_idx];
        inc           = {1'b0, head_reg[o_idx]} + 1'b1;
        lvl_before    = 1'b0;
        lvl_after     = 1'b0;
        head_next     = head_reg;
        count_next    = count_reg;
        sync_next     = sync_reg;
        sync_en_next  = sync_en_reg;
        send_irq_next = send_irq_reg;
        recv_irq_next = recv_irq_reg;
        err_next      = err_reg;
        enable_next   = enable_reg;
        asm_next      = asm_reg;
        lanes_next    = lanes_reg;
        latch_next    = latch_reg;
        res           = '0;
        mem           = '0;
        wr_addr       = '0;
        rd_addr       = '0;

        if (sum >= (PW+1)'(FIFO_DEPTH))
            sum = sum - (PW+1)'(FIFO_DEPTH);
        if (inc >= (PW+1)'(FIFO_DEPTH))
            inc = inc - (PW+1)'(FIFO_DEPTH);

        if (fire)
        begin
            if (acc.opcode == OP_WRITE)
            begin
                case (acc.address)
                    ADDR_SYNC_HI:
                    begin
                        sync_next[s_idx]    = acc.write_byte[3:0];
                        sync_en_next[s_idx] = acc.write_byte[6];
                        if (acc.write_byte[5] && sync_en_reg[o_idx])
                        begin
                            res.event_valid = 1'b1;
                            res.event_side  = o_idx;
                            res.event_kind  = EV_SYNC;
                        end
                    end
                    ADDR_CNT_LO:
                    begin
                        lvl_before = send_irq_reg[s_idx] && (count_reg[s_idx] == '0);
                        send_irq_next[s_idx] = acc.write_byte[2];
                        if (acc.write_byte[3])
                        begin
                            count_next[s_idx] = '0;
                            head_next[s_idx]  = '0;
                            latch_next[o_idx] = '0;
                        end
                        lvl_after = acc.write_byte[2] && (count_next[s_idx] == '0);
                        if (!lvl_before && lvl_after)
                        begin
                            res.event_valid = 1'b1;
                            res.event_side  = s_idx;
                            res.event_kind  = EV_SEND_EMPTY;
                        end
                    end
                    ADDR_CNT_HI:
                    begin
                        lvl_before = recv_irq_reg[s_idx] && (count_reg[o_idx] != '0);
                        if (acc.write_byte[6])
                            err_next[s_idx] = 1'b0;
                        recv_irq_next[s_idx] = acc.write_byte[2];
                        enable_next[s_idx]   = acc.write_byte[7];
                        lvl_after = acc.write_byte[2] && (count_reg[o_idx] != '0);
                        if (!lvl_before && lvl_after)
                        begin
                            res.event_valid = 1'b1;
                            res.event_side  = s_idx;
                            res.event_kind  = EV_RECV_NOT_EMPTY;
                        end
                    end
                    default:
                    begin
                        // Send register: gather bytes, push on the final one
                        if (acc.address[26:2] == ADDR_SEND0[26:2])
                        begin
                            if (!acc.last_byte)
                            begin
                                asm_next[s_idx]   = gathered;
                                lanes_next[s_idx] = glanes;
                            end
                            else
                            begin
                                asm_next[s_idx]   = '0;
                                lanes_next[s_idx] = '0;
                                if (enable_reg[s_idx])
                                begin
                                    lvl_before = recv_irq_reg[o_idx] && (count_reg[s_idx] != '0);
                                    if (count_reg[s_idx] == CW'(FIFO_DEPTH))
                                        err_next[s_idx] = 1'b1;
                                    else
                                    begin
                                        mem.wr_en         = 1'b1;
                                        mem.wr_side       = s_idx;
                                        mem.wr_data       = word;
                                        wr_addr           = sum[PW-1:0];
                                        count_next[s_idx] = count_reg[s_idx] + 1'b1;
                                        // Latch tracks the front word: new only if FIFO was empty
                                        if (count_reg[s_idx] == '0)
                                            latch_next[o_idx] = word;
                                    end
                                    lvl_after = recv_irq_reg[o_idx] && (count_next[s_idx] != '0);
                                    if (!lvl_before && lvl_after)
                                    begin
                                        res.event_valid = 1'b1;
                                        res.event_side  = o_idx;
                                        res.event_kind  = EV_RECV_NOT_EMPTY;
                                    end
                                end
                            end
                        end
                    end
                endcase
            end
            else
            begin
                case (acc.address)
                    ADDR_SYNC_LO:
                        res.read_byte = {4'd0, sync_reg[o_idx]};
                    ADDR_SYNC_HI:
                        res.read_byte = {1'b0, sync_en_reg[s_idx], 2'b00, sync_reg[s_idx]};
                    ADDR_CNT_LO:
                        res.read_byte = {5'd0, send_irq_reg[s_idx],
                                         count_reg[s_idx] == CW'(FIFO_DEPTH),
                                         count_reg[s_idx] == '0};
                    ADDR_CNT_HI:
                        res.read_byte = {enable_reg[s_idx], err_reg[s_idx], 3'd0,
                                         recv_irq_reg[s_idx],
                                         count_reg[o_idx] == CW'(FIFO_DEPTH),
                                         count_reg[o_idx] == '0};
                    default:
                    begin
                        // Receive register: final byte pops the other side's FIFO
                        if (acc.address[26:2] == ADDR_RECV0[26:2])
                        begin
                            res.read_byte = 8'(latch_reg[s_idx] >> {lane, 3'b000});
                            if (acc.last_byte && enable_reg[s_idx])
                            begin
                                lvl_before = send_irq_reg[o_idx] && (count_reg[o_idx] == '0);
                                if (count_reg[o_idx] == '0)
                                    err_next[s_idx] = 1'b1;
                                else
                                begin
                                    head_next[o_idx]  = inc[PW-1:0];
                                    count_next[o_idx] = count_reg[o_idx] - 1'b1;
                                    // Fetch the new front word unless the FIFO ran dry
                                    if (count_reg[o_idx] != CW'(1))
                                    begin
                                        mem.rd_en   = 1'b1;
                                        mem.rd_side = o_idx;
                                        rd_addr     = inc[PW-1:0];
                                    end
                                end
                                lvl_after = send_irq_reg[o_idx] && (count_next[o_idx] == '0);
                                if (!lvl_before && lvl_after)
                                begin
                                    res.event_valid = 1'b1;
                                    res.event_side  = o_idx;
                                    res.event_kind  = EV_SEND_EMPTY;
                                end
                            end
                        end
                    end
                endcase
            end
        end

        // Front word arriving from memory after a pop
        if (cap.en)
            latch_next[cap.side] = cap.data;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                head_reg[i]     <= '0;
                count_reg[i]    <= '0;
                sync_reg[i]     <= '0;
                sync_en_reg[i]  <= 1'b0;
                send_irq_reg[i] <= 1'b0;
                recv_irq_reg[i] <= 1'b0;
                err_reg[i]      <= 1'b0;
                enable_reg[i]   <= 1'b0;
                asm_reg[i]      <= '0;
                lanes_reg[i]    <= '0;
                latch_reg[i]    <= '0;
            end
        end
        else
        begin
            head_reg     <= head_next;
            count_reg    <= count_next;
            sync_reg     <= sync_next;
            sync_en_reg  <= sync_en_next;
            send_irq_reg <= send_irq_next;
            recv_irq_reg <= recv_irq_next;
            err_reg      <= err_next;
            enable_reg   <= enable_next;
            asm_reg      <= asm_next;
            lanes_reg    <= lanes_next;
            latch_reg    <= latch_next;
        end
    end

    // Fill counts stay within depth; capture never overlaps an access
    `DCMF_ASSERT(a_count0_range, count_reg[0] <= CW'(FIFO_DEPTH), "side 0 count over depth")
    `DCMF_ASSERT(a_count1_range, count_reg[1] <= CW'(FIFO_DEPTH), "side 1 count over depth")
    `DCMF_ASSERT(a_cap_no_fire, !(cap.en && fire), "latch capture during an access")

endmodule

FILE: sv/dual_cpu_mailbox_fifo.sv
// Top level of the dual CPU mailbox: handshake control, FIFO memories, result register.
//
// Channels: req carries one byte access per item (side, opcode, address,
// write_byte, last_byte); rsp returns one result item per access (read_byte
// and an optional interrupt event: event_valid, event_side, event_kind).
// Both use valid/ready; an item moves when both are high at a clock edge.
// The result is offered on rsp the cycle after the access is taken.
// Throughput: one access per cycle for most accesses while rsp is ready; a
// final receive read that leaves words in the FIFO holds req.ready low in ST_READ
// while the new front word is read from the FIFO memory into the receive latch.
// A single result register holds the item; while rsp is stalled req.ready
// stays low, and a new access is taken in the same cycle the result leaves.
// Reset (rst_n, async, active low) empties both FIFOs and clears all
// control, sync and latch registers; FIFO memory contents are not cleared.
// FIFO_DEPTH sets the entries per direction (2 to 256).
module dual_cpu_mailbox_fifo
    import dcmf_pkg::*;
#(
    parameter int FIFO_DEPTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    dcmf_acc_if.sink   req,
    dcmf_res_if.source rsp
);

`include "dual_cpu_mailbox_fifo_defines.svh"

    localparam int PW = $clog2(FIFO_DEPTH);

    dcmf_state_t   state_reg;
    dcmf_state_t   state_next;
    logic          rd_side_reg;
    logic          rd_side_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    res_t          out_data_reg;
    res_t          out_data_next;

    logic          fire;
    acc_t          acc;
    res_t          res;
    mem_cmd_t      mem_cmd;
    cap_t          cap;
    logic [PW-1:0] wr_addr;
    logic [PW-1:0] rd_addr;
    logic [31:0]   ram_rdata [2];

    assign acc.side       = req.side;
    assign acc.opcode     = req.opcode;
    assign acc.address    = req.address;
    assign acc.write_byte = req.write_byte;
    assign acc.last_byte  = req.last_byte;

    assign fire = req.valid && req.ready;

    assign cap.en   = (state_reg == ST_READ);
    assign cap.side = ~rd_side_reg;
    assign cap.data = ram_rdata[rd_side_reg];

    assign rsp.valid       = out_valid_reg;
    assign rsp.read_byte   = out_data_reg.read_byte;
    assign rsp.event_valid = out_data_reg.event_valid;
    assign rsp.event_side  = out_data_reg.event_side;
    assign rsp.event_kind  = out_data_reg.event_kind;

    dcmf_core #(
        .FIFO_DEPTH(FIFO_DEPTH)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .acc     (acc),
        .cap     (cap),
        .res     (res),
        .mem     (mem_cmd),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr)
    );

    // One FIFO memory per sending side
    for (genvar i = 0; i < 2; i++)
    begin : g_fifo_mem
        dcmf_ram #(
            .WIDTH(32),
            .DEPTH(FIFO_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (mem_cmd.wr_en && (mem_cmd.wr_side == 1'(i))),
            .waddr (wr_addr),
            .wdata (mem_cmd.wr_data),
            .re    (mem_cmd.rd_en && (mem_cmd.rd_side == 1'(i))),
            .raddr (rd_addr),
            .rdata (ram_rdata[i])
        );
    end

    // Access sequencing and result register control
    always_comb
    begin
        state_next     = state_reg;
        rd_side_next   = rd_side_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        req.ready      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                req.ready = !out_valid_reg || rsp.ready;
                if (fire && mem_cmd.rd_en)
                begin
                    state_next   = ST_READ;
                    rd_side_next = mem_cmd.rd_side;
                end
            end
            ST_READ:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase

        if (fire)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_side_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_side_reg   <= rd_side_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    `DCMF_ASSERT_NEXT(a_pop_reads, fire && mem_cmd.rd_en, state_reg == ST_READ, "pop read not tracked")
    `DCMF_ASSERT(a_no_rw_same, !(mem_cmd.wr_en && mem_cmd.rd_en), "FIFO write and read in one access")
    `DCMF_ASSERT_NEXT(a_result_follows, fire, rsp.valid, "accepted access gave no result")

endmodule
